// File: rtl/ofwm_pkg.sv
// ============================================================================
// ofwm_pkg : shared types and constants for the overwrite FIFO window mean
// Field widths, request codes and the default queue depth.
// ============================================================================
`default_nettype none

package ofwm_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int VALUE_W   = 32;
    localparam int RATE_W    = 8;
    localparam int FILL_W    = 4;

    // request codes carried on req_type
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [RATE_W-1:0]  rate_t;
    typedef logic [FILL_W-1:0]  fill_t;

endpackage

`default_nettype wire

// File: rtl/ofwm_div.sv
// ============================================================================
// ofwm_div : iterative restoring divider, one quotient bit per cycle
// Produces an 8-bit quotient; the caller guarantees the quotient fits.
// ============================================================================
`default_nettype none

module ofwm_div #(
    parameter int NUM_W = 11,
    parameter int DEN_W = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output ofwm_pkg::rate_t       quot
);
    import ofwm_pkg::*;

    localparam int STEP_W = $clog2(RATE_W);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    rate_t             shf_reg, shf_next;   // numerator bits in, quotient bits out
    logic [DEN_W:0]    trial;
    logic              qbit;

    assign trial = {rem_reg, shf_reg[RATE_W-1]};
    assign qbit  = (trial >= {1'b0, den_reg});
    assign done  = busy_reg && (step_reg == STEP_W'(RATE_W - 1));
    assign quot  = shf_reg;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        shf_next  = shf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            // high part of the numerator is already below the divisor
            rem_next  = DEN_W'(num >> RATE_W);
            den_next  = den;
            shf_next  = num[RATE_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            shf_next  = {shf_reg[RATE_W-2:0], qbit};
            step_next = step_reg + STEP_W'(1);
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        shf_reg <= shf_next;
    end

endmodule

`default_nettype wire

// File: rtl/overwrite_fifo_window_mean.sv
// ============================================================================
// overwrite_fifo_window_mean : overwriting circular FIFO with rate mean
// Holds DEPTH entries of payload and rate; reports the rounded-up mean rate on each enqueue.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one request item: an enqueue
//   (req_type = REQ_ENQ) of item_value / item_rate, or a dequeue of the
//   oldest entry. Every item yields exactly one result item on the output
//   channel (out_valid / out_stall).
//   An enqueue into a full queue drops the oldest entry first and flags
//   dropped_oldest. A dequeue of an empty queue returns zeros and was_empty.
//   A dequeue passes from acceptance through the read and done steps to
//   out_valid; an enqueue passes through read, divider start, divider wait
//   and done, the divider forming ceil(rate_sum / count) one quotient bit
//   per cycle. One item is in work at a time: in_stall is high from
//   acceptance until its result moves into the output register, so a new
//   item is not taken before the last one's result has moved there.
//   The output register frees the input side: a new item is taken while a
//   result still waits. If the receiver stalls, the finished result waits
//   in the sequencer until the output register empties.
//   Reset empties the queue (head, tail, count and sum cleared); the entry
//   memory is not cleared, since only held entries are ever used.
// ============================================================================
`default_nettype none

module overwrite_fifo_window_mean #(
    parameter int DEPTH = ofwm_pkg::DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // request channel
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             req_type,
    input  wire ofwm_pkg::value_t item_value,
    input  wire ofwm_pkg::rate_t  item_rate,
    // result channel
    output logic                  out_valid,
    input  wire logic             out_stall,
    output ofwm_pkg::rate_t       mean_rate,
    output ofwm_pkg::value_t      removed_value,
    output ofwm_pkg::rate_t       removed_rate,
    output logic                  was_empty,
    output logic                  dropped_oldest,
    output ofwm_pkg::fill_t       fill_count
);
    import ofwm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = $clog2(DEPTH * 255 + 1);
    localparam int NUM_W = $clog2(DEPTH * 256);

    // sequencer codes
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_READ     = 3'd1;
    localparam logic [2:0] ST_DIV_GO   = 3'd2;
    localparam logic [2:0] ST_DIV_WAIT = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    // ------------------------------------------------------------------
    // Control and queue state
    // ------------------------------------------------------------------
    logic [2:0]       state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             out_valid_reg, out_valid_next;

    // latched request
    logic             req_reg;
    value_t           val_reg;
    rate_t            rate_reg;

    // pending result fields, formed in the read step
    value_t           pend_value_reg, pend_value_next;
    rate_t            pend_rate_reg, pend_rate_next;
    logic             pend_empty_reg, pend_empty_next;
    logic             pend_drop_reg, pend_drop_next;

    // output register
    rate_t            mean_reg, mean_next;
    value_t           rv_reg, rv_next;
    rate_t            rr_reg, rr_next;
    logic             empty_reg, empty_next;
    logic             drop_reg, drop_next;
    fill_t            fill_reg, fill_next;

    // entry memory, registered read at the head slot
    value_t           mem_value [DEPTH];
    rate_t            mem_rate  [DEPTH];
    value_t           rd_value_reg;
    rate_t            rd_rate_reg;

    logic             in_take;
    logic             out_free;
    logic             wr_en;
    logic             full;
    logic             div_start;
    logic             div_done;
    rate_t            div_quot;
    logic [NUM_W-1:0] div_num;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = (count_reg == FULL_CNT);
    assign wr_en     = (state_reg == ST_READ) && (req_reg == REQ_ENQ);
    assign div_start = (state_reg == ST_DIV_GO);
    // ceil(sum / count) = floor((sum + count - 1) / count)
    assign div_num   = NUM_W'(sum_reg) + NUM_W'(count_reg) - NUM_W'(1);

    assign out_valid      = out_valid_reg;
    assign mean_rate      = mean_reg;
    assign removed_value  = rv_reg;
    assign removed_rate   = rr_reg;
    assign was_empty      = empty_reg;
    assign dropped_oldest = drop_reg;
    assign fill_count     = fill_reg;

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    ofwm_div #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (count_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        pend_value_next = pend_value_reg;
        pend_rate_next  = pend_rate_reg;
        pend_empty_next = pend_empty_reg;
        pend_drop_next  = pend_drop_reg;
        out_valid_next  = out_valid_reg;
        mean_next       = mean_reg;
        rv_next         = rv_reg;
        rr_next         = rr_reg;
        empty_next      = empty_reg;
        drop_next       = drop_reg;
        fill_next       = fill_reg;

        // retire the shown result once the receiver takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                pend_value_next = '0;
                pend_rate_next  = '0;
                pend_empty_next = 1'b0;
                pend_drop_next  = 1'b0;
                if (req_reg == REQ_ENQ)
                begin
                    // drop the oldest entry first when full, then store
                    if (full)
                    begin
                        pend_drop_next = 1'b1;
                        head_next      = (head_reg == LAST_SLOT) ? '0 : head_reg + PTR_W'(1);
                        sum_next       = sum_reg - SUM_W'(rd_rate_reg) + SUM_W'(rate_reg);
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        sum_next   = sum_reg + SUM_W'(rate_reg);
                    end
                    tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + PTR_W'(1);
                    state_next = ST_DIV_GO;
                end
                else
                begin
                    if (count_reg == '0)
                    begin
                        pend_empty_next = 1'b1;
                    end
                    else
                    begin
                        pend_value_next = rd_value_reg;
                        pend_rate_next  = rd_rate_reg;
                        head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + PTR_W'(1);
                        count_next = count_reg - CNT_W'(1);
                        sum_next   = sum_reg - SUM_W'(rd_rate_reg);
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold here until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    mean_next      = (req_reg == REQ_ENQ) ? div_quot : '0;
                    rv_next        = pend_value_reg;
                    rr_next        = pend_rate_reg;
                    empty_next     = pend_empty_reg;
                    drop_next      = pend_drop_reg;
                    fill_next      = FILL_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg  <= req_type;
            val_reg  <= item_value;
            rate_reg <= item_rate;
        end
        pend_value_reg <= pend_value_next;
        pend_rate_reg  <= pend_rate_next;
        pend_empty_reg <= pend_empty_next;
        pend_drop_reg  <= pend_drop_next;
        mean_reg       <= mean_next;
        rv_reg         <= rv_next;
        rr_reg         <= rr_next;
        empty_reg      <= empty_next;
        drop_reg       <= drop_next;
        fill_reg       <= fill_next;
    end

    // entry memory: read the head slot on acceptance, write the tail slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_value[tail_reg] <= val_reg;
            mem_rate[tail_reg]  <= rate_reg;
        end
        if (in_take)
        begin
            rd_value_reg <= mem_value[head_reg];
            rd_rate_reg  <= mem_rate[head_reg];
        end
    end

endmodule

`default_nettype wire

// File: rtl/ofwm_checker.sv
// ============================================================================
// ofwm_checker : port-level checks for the overwrite FIFO window mean
// Watches the request and result channels and binds to the top level.
// ============================================================================
`default_nettype none

module ofwm_checker #(
    parameter int DEPTH = ofwm_pkg::DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_stall,
    input  wire logic             out_valid,
    input  wire logic             out_stall,
    input  wire ofwm_pkg::rate_t  mean_rate,
    input  wire ofwm_pkg::value_t removed_value,
    input  wire ofwm_pkg::rate_t  removed_rate,
    input  wire logic             was_empty,
    input  wire logic             dropped_oldest,
    input  wire ofwm_pkg::fill_t  fill_count
);
    import ofwm_pkg::*;

    localparam fill_t FULL_FILL = FILL_W'(DEPTH);

    // an accepted item holds off the next one
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after an item was taken");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mean_rate)
            && $stable(removed_value) && $stable(fill_count))
        else $error("result changed while stalled");

    // an empty dequeue reports zeros and an empty queue
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_empty |-> removed_value == '0 && removed_rate == '0
            && mean_rate == '0 && fill_count == '0 && !dropped_oldest)
        else $error("empty dequeue with nonzero fields");

    // an overwrite leaves the queue full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped_oldest |-> fill_count == FULL_FILL && !was_empty
            && removed_value == '0)
        else $error("overwrite without a full queue");

    // the fill count never exceeds the depth
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (DEPTH > 15) || (fill_count <= FULL_FILL))
        else $error("fill count beyond depth");

endmodule

bind overwrite_fifo_window_mean ofwm_checker #(.DEPTH(DEPTH)) u_ofwm_checker (.*);

`default_nettype wire
